>>> sv/tdma_sync_pkg.sv
`timescale 1ns / 1ps
// Package for the TDMA beacon slot sync controller: word types, phase codes and time constants.
// It depends on nothing else and is read by tdma_beacon_slot_sync.

package tdma_sync_pkg;

   // Widths of the time arithmetic.
   localparam int TimeWidth  = 64;
   localparam int FrameWidth = 32;
   localparam int DelayWidth = 25;
   localparam int SlotWidth  = 5;
   localparam int PhaseWidth = 2;
   // 100 ms fits in 27 bits; the slot middle (at most 146 ms) and 100 ms plus a
   // 25-bit delay fit in 28 bits.
   localparam int FrameNsWidth = 27;
   localparam int ShortNsWidth = 28;
   localparam int ProdWidth    = FrameWidth + FrameNsWidth;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   localparam logic [FrameNsWidth-1:0] FRAME_NS  = 27'd100_000_000;
   localparam logic [ShortNsWidth-1:0] NS_PER_MS = 28'd1_000_000;

   // Configuration register indexes.
   localparam logic [CsrAddrWidth-3:0] REG_SLOT_NUMBER = 1'b0;

   // Event kinds.
   localparam logic OP_TIMER  = 1'b0;
   localparam logic OP_BEACON = 1'b1;

   // Phase codes.
   localparam logic [PhaseWidth-1:0] PH_INIT        = 2'd0;
   localparam logic [PhaseWidth-1:0] PH_WAIT_BEACON = 2'd1;
   localparam logic [PhaseWidth-1:0] PH_WAIT_SLOT   = 2'd2;

   typedef struct packed {
      logic                  op;
      logic [TimeWidth-1:0]  now_ns;
      logic [FrameWidth-1:0] rx_frame;
      logic [DelayWidth-1:0] rx_delay_ns;
      logic [DelayWidth-1:0] random_delay_ns;
   } req_type;

   typedef struct packed {
      logic                  arm_timer;
      logic [TimeWidth-1:0]  deadline_ns;
      logic                  send_beacon;
      logic [FrameWidth-1:0] beacon_frame;
      logic [DelayWidth-1:0] beacon_delay_ns;
      logic                  send_slot;
      logic [PhaseWidth-1:0] phase;
   } rsp_type;

   // Middle of the own slot, (22 + 4 * slot) ms after the superframe start.
   function automatic logic [ShortNsWidth-1:0] slot_middle_ns(input logic [SlotWidth-1:0] slot);
      logic [ShortNsWidth-1:0] ms;
      ms = ShortNsWidth'(22) + ShortNsWidth'({slot, 2'b00});
      return ShortNsWidth'(ms * NS_PER_MS);
   endfunction

endpackage

>>> sv/tdma_beacon_slot_sync.sv
`timescale 1ns / 1ps
// TDMA beacon slot sync controller: one result word per event word. An accepted word is held
// in the input register, then its result in the result register. Throughput is one word
// per cycle while result words are taken; the state update sits between the two registers.
// Reset (synchronous, active high) returns the phase to init, clears the counters and
// times, and sets slot_number to 0. Depends on tdma_sync_pkg.

module tdma_beacon_slot_sync (
   input  logic                                    clock,
   input  logic                                    reset,
   // Event words.
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  tdma_sync_pkg::req_type                  req_data,
   // Result words.
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output tdma_sync_pkg::rsp_type                  rsp_data,
   // Configuration port.
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [tdma_sync_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [tdma_sync_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [tdma_sync_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                    pready
);

   localparam int TW = tdma_sync_pkg::TimeWidth;
   localparam int FW = tdma_sync_pkg::FrameWidth;
   localparam int DW = tdma_sync_pkg::DelayWidth;
   localparam int SW = tdma_sync_pkg::SlotWidth;
   localparam int PW = tdma_sync_pkg::PhaseWidth;
   localparam int NW = tdma_sync_pkg::ShortNsWidth;
   localparam int MW = tdma_sync_pkg::ProdWidth;

   // ------------------------------------------------------------------
   // Configuration. The slot middle is derived once at write time so that
   // the event path only adds it.
   // ------------------------------------------------------------------
   logic [SW-1:0] slot_number_ff, slot_number_in;
   logic [NW-1:0] slot_mid_ff, slot_mid_in;
   logic          csr_write;
   logic          csr_hit;

   assign pready    = 1'b1;
   assign csr_hit   = (paddr[tdma_sync_pkg::CsrAddrWidth-1:2] == tdma_sync_pkg::REG_SLOT_NUMBER);
   assign csr_write = psel && penable && pwrite && csr_hit;

   always_comb begin
      slot_number_in = slot_number_ff;
      slot_mid_in    = slot_mid_ff;
      if (csr_write) begin
         slot_number_in = pwdata[SW-1:0];
         slot_mid_in    = tdma_sync_pkg::slot_middle_ns(pwdata[SW-1:0]);
      end
   end

   assign prdata = csr_hit ? {{(tdma_sync_pkg::CsrDataWidth-SW){1'b0}}, slot_number_ff} : '0;

   // ------------------------------------------------------------------
   // Handshake. The result register loads whenever it is empty or being
   // taken; the input register moves on in the same condition.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_advance;
   logic s1_fire;
   logic req_fire;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
   assign rsp_valid    = rsp_valid_ff;

   // ------------------------------------------------------------------
   // Input stage. Everything that depends only on the event word is worked
   // out here: the received frame times 100 ms (the event path's one multiplier), the
   // sender's superframe start, and the deadlines built from the event time.
   // ------------------------------------------------------------------
   logic          s1_op_ff, s1_op_in;
   logic [TW-1:0] s1_now_ff, s1_now_in;
   logic [FW-1:0] s1_rx_frame_ff, s1_rx_frame_in;
   logic [DW-1:0] s1_rx_delay_ff, s1_rx_delay_in;
   logic [DW-1:0] s1_rnd_ff, s1_rnd_in;
   logic [TW-1:0] s1_rx_prod_ff, s1_rx_prod_in;     // rx_frame * 100 ms
   logic [TW-1:0] s1_now_rx_ff, s1_now_rx_in;       // now - rx_delay
   logic [TW-1:0] s1_now_mid_ff, s1_now_mid_in;     // now + slot middle
   logic [TW-1:0] s1_rx_mid_ff, s1_rx_mid_in;       // now - rx_delay + slot middle
   logic [NW-1:0] s1_wait_ff, s1_wait_in;           // 100 ms + random delay
   logic [MW-1:0] rx_prod;

   always_comb begin
      rx_prod        = MW'(req_data.rx_frame) * MW'(tdma_sync_pkg::FRAME_NS);
      s1_op_in       = req_data.op;
      s1_now_in      = req_data.now_ns;
      s1_rx_frame_in = req_data.rx_frame;
      s1_rx_delay_in = req_data.rx_delay_ns;
      s1_rnd_in      = req_data.random_delay_ns;
      s1_rx_prod_in  = TW'(rx_prod);
      s1_now_rx_in   = req_data.now_ns - TW'(req_data.rx_delay_ns);
      s1_now_mid_in  = req_data.now_ns + TW'(slot_mid_ff);
      s1_rx_mid_in   = s1_now_rx_in + TW'(slot_mid_ff);
      s1_wait_in     = NW'(tdma_sync_pkg::FRAME_NS) + NW'(req_data.random_delay_ns);
   end

   // ------------------------------------------------------------------
   // Event stage. The state moves on exactly when a word leaves the input
   // register, so each event sees what the previous one left.
   //
   // While waiting for a beacon the superframe start always equals
   // frame_count * 100 ms + time_offset, which lets the timer case step it
   // by one frame and lets a smaller beacon offset yield now - rx_delay
   // directly as the new start. When the frame counter wraps to zero the
   // product drops out and the start is the offset itself.
   // ------------------------------------------------------------------
   logic [PW-1:0] phase_ff, phase_in;
   logic [FW-1:0] frame_count_ff, frame_count_in;
   logic [TW-1:0] time_offset_ff, time_offset_in;
   logic [TW-1:0] sf_start_ff, sf_start_in;
   logic [DW-1:0] own_delay_ff, own_delay_in;
   tdma_sync_pkg::rsp_type rsp_in;
   tdma_sync_pkg::rsp_type rsp_ff;

   logic [TW-1:0] cand_offset;
   logic [TW-1:0] next_frame_start;
   logic [TW-1:0] rx_start;
   logic [FW-1:0] frame_inc;

   always_comb begin
      cand_offset      = s1_now_rx_ff - s1_rx_prod_ff;
      frame_inc        = frame_count_ff + FW'(1);
      next_frame_start = (frame_inc == '0) ? time_offset_ff
                                           : sf_start_ff + TW'(tdma_sync_pkg::FRAME_NS);
      rx_start         = s1_rx_prod_ff + time_offset_ff;

      phase_in       = phase_ff;
      frame_count_in = frame_count_ff;
      time_offset_in = time_offset_ff;
      sf_start_in    = sf_start_ff;
      own_delay_in   = own_delay_ff;
      rsp_in         = '0;

      case (phase_ff)
         tdma_sync_pkg::PH_INIT: begin
            if (s1_op_ff == tdma_sync_pkg::OP_TIMER) begin
               // No beacon heard yet: this node starts the superframe itself.
               sf_start_in        = s1_now_ff;
               time_offset_in     = s1_now_ff;
               rsp_in.deadline_ns = s1_now_mid_ff;
            end else begin
               frame_count_in     = s1_rx_frame_ff;
               own_delay_in       = s1_rx_delay_ff;
               sf_start_in        = s1_now_rx_ff;
               time_offset_in     = cand_offset;
               rsp_in.deadline_ns = s1_rx_mid_ff;
            end
            rsp_in.arm_timer = 1'b1;
            phase_in         = tdma_sync_pkg::PH_WAIT_SLOT;
         end
         tdma_sync_pkg::PH_WAIT_BEACON: begin
            if (s1_op_ff == tdma_sync_pkg::OP_TIMER) begin
               // Own backoff ran out first: send the beacon for the next frame.
               frame_count_in         = frame_inc;
               rsp_in.send_beacon     = 1'b1;
               rsp_in.beacon_frame    = frame_inc;
               rsp_in.beacon_delay_ns = own_delay_ff;
               sf_start_in            = next_frame_start;
               rsp_in.deadline_ns     = next_frame_start + TW'(slot_mid_ff);
            end else begin
               frame_count_in = s1_rx_frame_ff;
               own_delay_in   = s1_rx_delay_ff;
               if (cand_offset < time_offset_ff) begin
                  // An earlier clock wins; the start follows the sender exactly.
                  time_offset_in     = cand_offset;
                  sf_start_in        = s1_now_rx_ff;
                  rsp_in.deadline_ns = s1_rx_mid_ff;
               end else begin
                  sf_start_in        = rx_start;
                  rsp_in.deadline_ns = rx_start + TW'(slot_mid_ff);
               end
            end
            rsp_in.arm_timer = 1'b1;
            phase_in         = tdma_sync_pkg::PH_WAIT_SLOT;
         end
         tdma_sync_pkg::PH_WAIT_SLOT: begin
            // Beacons heard while waiting for the own slot are dropped.
            if (s1_op_ff == tdma_sync_pkg::OP_TIMER) begin
               rsp_in.send_slot   = 1'b1;
               own_delay_in       = s1_rnd_ff;
               rsp_in.arm_timer   = 1'b1;
               rsp_in.deadline_ns = sf_start_ff + TW'(s1_wait_ff);
               phase_in           = tdma_sync_pkg::PH_WAIT_BEACON;
            end
         end
         default: begin
            // Unused phase code: the event is ignored.
         end
      endcase

      rsp_in.phase = phase_in;
   end

   assign rsp_data = rsp_ff;

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_number_ff <= '0;
         slot_mid_ff    <= tdma_sync_pkg::slot_middle_ns('0);
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= tdma_sync_pkg::PH_INIT;
         frame_count_ff <= '0;
         time_offset_ff <= '0;
         sf_start_ff    <= '0;
         own_delay_ff   <= '0;
      end else begin
         slot_number_ff <= slot_number_in;
         slot_mid_ff    <= slot_mid_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (s1_fire) begin
            phase_ff       <= phase_in;
            frame_count_ff <= frame_count_in;
            time_offset_ff <= time_offset_in;
            sf_start_ff    <= sf_start_in;
            own_delay_ff   <= own_delay_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff       <= s1_op_in;
         s1_now_ff      <= s1_now_in;
         s1_rx_frame_ff <= s1_rx_frame_in;
         s1_rx_delay_ff <= s1_rx_delay_in;
         s1_rnd_ff      <= s1_rnd_in;
         s1_rx_prod_ff  <= s1_rx_prod_in;
         s1_now_rx_ff   <= s1_now_rx_in;
         s1_now_mid_ff  <= s1_now_mid_in;
         s1_rx_mid_ff   <= s1_rx_mid_in;
         s1_wait_ff     <= s1_wait_in;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for tdma_beacon_slot_sync: random and directed event words,
// an in-bench predictor of the sync state and an APB-style slot register exercise.
// Depends on tdma_sync_pkg and the tdma_beacon_slot_sync RTL.

module tb_top;

   localparam int TW = tdma_sync_pkg::TimeWidth;
   localparam int FW = tdma_sync_pkg::FrameWidth;
   localparam int DW = tdma_sync_pkg::DelayWidth;
   localparam int SW = tdma_sync_pkg::SlotWidth;
   localparam int PW = tdma_sync_pkg::PhaseWidth;
   localparam int AW = tdma_sync_pkg::CsrAddrWidth;
   localparam int CW = tdma_sync_pkg::CsrDataWidth;

   // Byte address of the slot register: register index times four.
   localparam logic [AW-1:0] SLOT_ADDR = {tdma_sync_pkg::REG_SLOT_NUMBER, 2'b00};
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int DRAIN_LIMIT  = 2_000;
   localparam int PHASE_EVENTS = 450;
   localparam logic [DW-1:0] DELAY_MAX = 25'd19_999_999;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   tdma_sync_pkg::req_type req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   tdma_sync_pkg::rsp_type rsp_data;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [AW-1:0]          paddr;
   logic [CW-1:0]          pwdata;
   logic [CW-1:0]          prdata;
   logic                   pready;

   tdma_beacon_slot_sync u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Event words waiting to be offered, and the results the predictor says are due.
   tdma_sync_pkg::req_type event_words[$];
   tdma_sync_pkg::rsp_type due_results[$];

   // Predicted controller state. The slot index follows every completed register write.
   logic [PW-1:0] phase_now;
   logic [FW-1:0] frame_no;
   logic [TW-1:0] offset_ns;
   logic [TW-1:0] sf_start_ns;
   logic [DW-1:0] own_delay_ns;
   logic [SW-1:0] slot_no;

   // Stimulus-side notion of time and frame, so that most events look like a real network.
   logic [TW-1:0] stim_now_ns;
   logic [FW-1:0] stim_frame;

   int  cycle_count;
   int  mismatch_count;
   int  accepted_count;
   int  checked_count;
   int  beacon_tx_count;
   int  slot_tx_count;
   int  offset_pull_count;
   bit  req_taken;
   // While set, neither side inserts gaps or stalls.
   bit  steady;

   // 20 ns clock.
   always #10 clock = ~clock;

   // Works out the one result that an event word causes and advances the predicted state.
   // All time arithmetic wraps at 64 bits, the frame counter at 32 bits.
   function automatic tdma_sync_pkg::rsp_type next_sync_result(
      input tdma_sync_pkg::req_type ev);
      tdma_sync_pkg::rsp_type res;
      logic [TW-1:0]          mid_ns;
      logic [TW-1:0]          cand_ns;
      logic [TW-1:0]          frame_len;
      res       = '0;
      frame_len = 64'(tdma_sync_pkg::FRAME_NS);
      mid_ns    = (64'd22 + 64'd4 * 64'(slot_no)) * 64'(tdma_sync_pkg::NS_PER_MS);
      case (phase_now)
         tdma_sync_pkg::PH_INIT: begin
            if (ev.op == tdma_sync_pkg::OP_TIMER) begin
               // Nobody else is on the air: this node opens superframe zero now.
               sf_start_ns = ev.now_ns;
               offset_ns   = ev.now_ns;
            end else begin
               // Join the network on the heard beacon's frame and timing.
               frame_no     = ev.rx_frame;
               own_delay_ns = ev.rx_delay_ns;
               sf_start_ns  = ev.now_ns - 64'(ev.rx_delay_ns);
               offset_ns    = sf_start_ns - 64'(frame_no) * frame_len;
            end
            res.arm_timer   = 1'b1;
            res.deadline_ns = sf_start_ns + mid_ns;
            phase_now       = tdma_sync_pkg::PH_WAIT_SLOT;
         end
         tdma_sync_pkg::PH_WAIT_BEACON: begin
            if (ev.op == tdma_sync_pkg::OP_TIMER) begin
               // Our backoff ran out first, so we send the beacon for the next frame.
               frame_no            = frame_no + 32'd1;
               res.send_beacon     = 1'b1;
               res.beacon_frame    = frame_no;
               res.beacon_delay_ns = own_delay_ns;
            end else begin
               frame_no     = ev.rx_frame;
               own_delay_ns = ev.rx_delay_ns;
               cand_ns = ev.now_ns - 64'(frame_no) * frame_len - 64'(ev.rx_delay_ns);
               // Keep the earliest offset; the compare is unsigned on wrapped values.
               if (cand_ns < offset_ns) begin
                  offset_ns = cand_ns;
                  offset_pull_count++;
               end
            end
            sf_start_ns     = 64'(frame_no) * frame_len + offset_ns;
            res.arm_timer   = 1'b1;
            res.deadline_ns = sf_start_ns + mid_ns;
            phase_now       = tdma_sync_pkg::PH_WAIT_SLOT;
         end
         tdma_sync_pkg::PH_WAIT_SLOT: begin
            // A beacon heard while waiting for the slot changes nothing.
            if (ev.op == tdma_sync_pkg::OP_TIMER) begin
               res.send_slot   = 1'b1;
               own_delay_ns    = ev.random_delay_ns;
               res.arm_timer   = 1'b1;
               res.deadline_ns = sf_start_ns + frame_len + 64'(own_delay_ns);
               phase_now       = tdma_sync_pkg::PH_WAIT_BEACON;
            end
         end
         default: begin
         end
      endcase
      res.phase = phase_now;
      if (res.send_beacon) beacon_tx_count++;
      if (res.send_slot) slot_tx_count++;
      return res;
   endfunction

   // Compares one result word with the oldest one due, field by field.
   task automatic check_result(input tdma_sync_pkg::rsp_type got);
      tdma_sync_pkg::rsp_type want;
      string                  bad;
      bad = "";
      if (due_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: result word with nothing due: deadline=%h phase=%0d",
                     got.deadline_ns, got.phase);
      end else begin
         want = due_results.pop_front();
         checked_count++;
         if (got.arm_timer !== want.arm_timer) bad = {bad, " arm_timer"};
         if (got.deadline_ns !== want.deadline_ns) bad = {bad, " deadline_ns"};
         if (got.send_beacon !== want.send_beacon) bad = {bad, " send_beacon"};
         if (got.beacon_frame !== want.beacon_frame) bad = {bad, " beacon_frame"};
         if (got.beacon_delay_ns !== want.beacon_delay_ns) bad = {bad, " beacon_delay_ns"};
         if (got.send_slot !== want.send_slot) bad = {bad, " send_slot"};
         if (got.phase !== want.phase) bad = {bad, " phase"};
         if (bad != "") begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("ERROR: result %0d differs in%s", checked_count, bad);
               $display("  expected arm=%b dl=%h bcn=%b frm=%h dly=%h slot=%b ph=%0d",
                        want.arm_timer, want.deadline_ns, want.send_beacon,
                        want.beacon_frame, want.beacon_delay_ns, want.send_slot, want.phase);
               $display("  actual   arm=%b dl=%h bcn=%b frm=%h dly=%h slot=%b ph=%0d",
                        got.arm_timer, got.deadline_ns, got.send_beacon,
                        got.beacon_frame, got.beacon_delay_ns, got.send_slot, got.phase);
            end
         end
      end
   endtask

   // Monitor: samples both channels and the register port at the rising edge. A result
   // is checked before the word accepted at the same edge is predicted.
   always @(posedge clock) begin
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) begin
            req_taken = 1'b1;
            accepted_count++;
            due_results.push_back(next_sync_result(req_data));
         end
         if (psel && penable && pwrite && pready && paddr == SLOT_ADDR)
            slot_no = pwdata[SW-1:0];
      end
   end

   // Driver: changes inputs at the falling edge. A word stays on the bus until it is
   // taken; a new one follows at once unless this cycle is picked as a gap.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (event_words.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
               req_data  <= event_words.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= steady || ($urandom_range(99) >= 20);
      end
   end

   task automatic push_event(input logic op, input logic [TW-1:0] now_ns,
                             input logic [FW-1:0] rx_frame,
                             input logic [DW-1:0] rx_delay,
                             input logic [DW-1:0] rnd_delay);
      tdma_sync_pkg::req_type ev;
      ev.op              = op;
      ev.now_ns          = now_ns;
      ev.rx_frame        = rx_frame;
      ev.rx_delay_ns     = rx_delay;
      ev.random_delay_ns = rnd_delay;
      event_words.push_back(ev);
   endtask

   // Random events. Most advance time by up to 150 ms and carry frame numbers close to
   // the running one, which is how a live network behaves; the rest are jumps anywhere
   // in the 64-bit time line and arbitrary frames. Delays are mostly within 20 ms, now
   // and then anywhere in their 25 bits.
   task automatic push_random_events(input int count);
      logic          op;
      logic [FW-1:0] frame;
      logic [DW-1:0] rx_delay;
      logic [DW-1:0] rnd_delay;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(99) < 60) ? tdma_sync_pkg::OP_TIMER : tdma_sync_pkg::OP_BEACON;
         if ($urandom_range(99) < 80)
            stim_now_ns = stim_now_ns + 64'($urandom_range(150_000_000));
         else
            stim_now_ns = {$urandom, $urandom};
         if (op == tdma_sync_pkg::OP_TIMER) stim_frame = stim_frame + 32'd1;
         frame     = ($urandom_range(99) < 70) ? stim_frame + 32'($urandom_range(2))
                                               : 32'($urandom);
         rx_delay  = ($urandom_range(99) < 90) ? DW'($urandom_range(DELAY_MAX))
                                               : DW'($urandom);
         rnd_delay = ($urandom_range(99) < 90) ? DW'($urandom_range(DELAY_MAX))
                                               : DW'($urandom);
         push_event(op, stim_now_ns, frame, rx_delay, rnd_delay);
      end
   endtask

   // One APB transfer: setup cycle, then access cycle. Read data is taken at the edge
   // that closes the access cycle.
   task automatic csr_access(input logic wr, input logic [AW-1:0] addr,
                             input logic [CW-1:0] wdata,
                             output logic [CW-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Writes the slot register and reads it back.
   task automatic set_slot(input logic [SW-1:0] slot);
      logic [CW-1:0] rdata;
      csr_access(1'b1, SLOT_ADDR, CW'(slot), rdata);
      csr_access(1'b0, SLOT_ADDR, '0, rdata);
      if (rdata[SW-1:0] !== slot) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: slot register read %h, expected %h", rdata, slot);
      end
   endtask

   // Lets every queued word go in and every due result come out, then allows for the
   // two-register pipeline before the register port is touched again.
   task automatic wait_drained;
      while (event_words.size() != 0 || req_valid) @(posedge clock);
      for (int n = 0; n < DRAIN_LIMIT && due_results.size() != 0; n++) @(posedge clock);
      if (due_results.size() != 0) begin
         if (mismatch_count < 10)
            $display("ERROR: %0d results never arrived", due_results.size());
         mismatch_count += due_results.size();
         due_results.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // Watchdog on the cycle count.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("FAIL tdma_beacon_slot_sync");
      $finish;
   end

   initial begin
      logic [SW-1:0] mid_slot;
      int            calm_phase;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      phase_now    = tdma_sync_pkg::PH_INIT;
      frame_no     = '0;
      offset_ns    = '0;
      sf_start_ns  = '0;
      own_delay_ns = '0;
      slot_no      = '0;
      stim_now_ns  = 64'd5_000_000_000;
      stim_frame   = 32'd40;
      steady       = 1'b0;
      calm_phase   = $urandom_range(3);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, slot register still at its reset value of zero. Reset happens only
      // once, so the seed picks whether the node starts the network or joins it.
      push_event($urandom_range(1) ? tdma_sync_pkg::OP_BEACON : tdma_sync_pkg::OP_TIMER,
                 64'd1_000_000_000, 32'd5, 25'd12_345_678, 25'd0);
      // Beacon while waiting for the slot is dropped, even with time and frame at their top.
      push_event(tdma_sync_pkg::OP_BEACON, '1, '1, DELAY_MAX, DELAY_MAX);
      push_event(tdma_sync_pkg::OP_TIMER, 64'd1_030_000_000, 32'd0, 25'd0, DELAY_MAX);
      // Timer while waiting for a beacon: this node sends the beacon.
      push_event(tdma_sync_pkg::OP_TIMER, 64'd1_120_000_000, 32'd0, 25'd0, 25'd0);
      push_event(tdma_sync_pkg::OP_TIMER, 64'd1_130_000_000, 32'd0, 25'd0, 25'd0);
      // Heard beacon with the largest frame; its offset wraps high and is not taken.
      push_event(tdma_sync_pkg::OP_BEACON, 64'd0, '1, DELAY_MAX, 25'd0);
      // Backoff beyond 20 ms is used as given.
      push_event(tdma_sync_pkg::OP_TIMER, 64'd1_250_000_000, 32'd0, 25'd0, '1);
      // Own beacon after the largest frame wraps the counter to zero.
      push_event(tdma_sync_pkg::OP_TIMER, 64'd1_300_000_000, 32'd0, 25'd0, 25'd7);
      push_event(tdma_sync_pkg::OP_TIMER, 64'd1_330_000_000, 32'd0, 25'd0, 25'd9_000_000);
      // Beacon at time zero, frame zero, no delay: the offset drops to zero.
      push_event(tdma_sync_pkg::OP_BEACON, 64'd0, 32'd0, 25'd0, '1);
      push_event(tdma_sync_pkg::OP_BEACON, 64'd77, 32'd3, 25'd3, 25'd3);
      push_event(tdma_sync_pkg::OP_TIMER, 64'd22_000_000, 32'd0, 25'd0, 25'd1);
      // Beacon carrying a delay beyond 20 ms, at the top of the time range.
      push_event(tdma_sync_pkg::OP_BEACON, '1, 32'd0, '1, 25'd0);
      push_event(tdma_sync_pkg::OP_TIMER, 64'd500_000_000, 32'd0, 25'd0, 25'd4_000_000);
      // A beacon whose offset is the largest value never moves the offset.
      push_event(tdma_sync_pkg::OP_BEACON, '1, 32'd0, 25'd0, 25'd0);
      push_event(tdma_sync_pkg::OP_TIMER, 64'd700_000_000, 32'd0, 25'd0, 25'd0);
      push_event(tdma_sync_pkg::OP_TIMER, 64'd800_000_000, 32'd0, 25'd0, 25'd0);
      wait_drained();

      // Random phases, each under another slot: the last in-range slot, the largest code
      // the register holds, a random in-range slot and back to zero. One of them runs
      // with no gaps or stalls on either side.
      mid_slot = SW'($urandom_range(18, 1));
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: set_slot(5'd19);
            1: set_slot(5'd31);
            2: set_slot(mid_slot);
            default: set_slot(5'd0);
         endcase
         steady = (p == calm_phase);
         push_random_events(PHASE_EVENTS);
         wait_drained();
      end
      steady = 1'b0;

      $display("Run covered %0d event words and %0d checked results",
               accepted_count, checked_count);
      $display("under slots 0, 19, 31 and %0d; beacons sent: %0d, slot messages: %0d, %s%0d.",
               mid_slot, beacon_tx_count, slot_tx_count, "offset pulls: ",
               offset_pull_count);
      if (mismatch_count == 0) begin
         $display("PASS tdma_beacon_slot_sync");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("FAIL tdma_beacon_slot_sync");
      end
      $finish;
   end

endmodule
